// ----- design/ascon_pkg.sv -----
// Shared types and constants for the Ascon-128 encryption block.
// Holds payload structs, command codes, controller/datapath interface structs
// and the round constant table. No dependencies.
`default_nettype none

package ascon_pkg;

    localparam int LANE_W   = 64;
    localparam int NUM_LANES = 5;
    localparam int ROUNDS_A = 12;
    localparam int ROUNDS_B = 6;
    localparam int RND_W    = $clog2(ROUNDS_A);

    localparam logic [RND_W-1:0] RND_START_A = RND_W'(ROUNDS_A - ROUNDS_A);
    localparam logic [RND_W-1:0] RND_START_B = RND_W'(ROUNDS_A - ROUNDS_B);
    localparam logic [RND_W-1:0] RND_LAST    = RND_W'(ROUNDS_A - 1);

    localparam logic [LANE_W-1:0] LANE0_IV = 64'h8040_0c06_0000_0000;

    localparam logic [7:0] ROUND_CONST [ROUNDS_A] = '{
        8'hF0, 8'hE1, 8'hD2, 8'hC3, 8'hB4, 8'hA5,
        8'h96, 8'h87, 8'h78, 8'h69, 8'h5A, 8'h4B
    };

    typedef enum logic [2:0] {
        CMD_INIT     = 3'd0,
        CMD_AD_FULL  = 3'd1,
        CMD_AD_FINAL = 3'd2,
        CMD_PT_FULL  = 3'd3,
        CMD_PT_FINAL = 3'd4
    } cmd_t;

    localparam logic CFG_KEY_UPPER = 1'b0;
    localparam logic CFG_KEY_LOWER = 1'b1;

    localparam logic KIND_CT  = 1'b0;
    localparam logic KIND_TAG = 1'b1;

    typedef logic [NUM_LANES-1:0][LANE_W-1:0] lanes_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [LANE_W-1:0] word_upper;
        logic [LANE_W-1:0] word_lower;
        logic [3:0]        valid_bytes;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [LANE_W-1:0] out_upper;
        logic [LANE_W-1:0] out_lower;
        logic [3:0]        out_bytes;
        logic              is_last;
    } out_item_t;

    typedef struct packed {
        logic             buf_load;
        logic             load_init;
        logic             do_round;
        logic [RND_W-1:0] rc_idx;
        logic             absorb;
        logic             pad_only;
        logic             dsep;
        logic             key12;
        logic             key34;
        logic             load_ct;
        logic             load_tag;
    } dp_ctl_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- design/ascon_datapath.sv -----
// Datapath: 320-bit state, one Ascon round per cycle, key registers,
// item buffer and result register. Depends on ascon_pkg.
`default_nettype none

module ascon_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ascon_pkg::dp_ctl_t    dp_ctl,
    output ascon_pkg::dp_status_t      st,
    input  wire ascon_pkg::in_item_t   item,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [63:0]           cfg_data,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output ascon_pkg::out_item_t       result
);

    function automatic logic [63:0] ror64(input logic [63:0] v, input int unsigned n);
        return (v >> n) | (v << (64 - n));
    endfunction

    function automatic ascon_pkg::lanes_t ascon_round(input ascon_pkg::lanes_t s,
                                                      input logic [7:0] c);
        logic [63:0] x0, x1, x2, x3, x4;
        logic [63:0] t0, t1, t2, t3, t4;
        ascon_pkg::lanes_t r;
        x0 = s[0];
        x1 = s[1];
        x2 = s[2] ^ {56'd0, c};
        x3 = s[3];
        x4 = s[4];
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;
        r[0] = x0 ^ ror64(x0, 19) ^ ror64(x0, 28);
        r[1] = x1 ^ ror64(x1, 61) ^ ror64(x1, 39);
        r[2] = x2 ^ ror64(x2, 1) ^ ror64(x2, 6);
        r[3] = x3 ^ ror64(x3, 10) ^ ror64(x3, 17);
        r[4] = x4 ^ ror64(x4, 7) ^ ror64(x4, 41);
        return r;
    endfunction

    function automatic logic [63:0] byte_mask(input logic [2:0] n);
        return ~(64'hFFFF_FFFF_FFFF_FFFF >> {n, 3'b000});
    endfunction

    function automatic logic [63:0] pad_bit(input logic [2:0] n);
        return 64'h8000_0000_0000_0000 >> {n, 3'b000};
    endfunction

    ascon_pkg::lanes_t   lanes_reg, lanes_next;
    ascon_pkg::lanes_t   stage0, stage1;
    ascon_pkg::in_item_t buf_reg;
    ascon_pkg::out_item_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [63:0]         key_upper_reg, key_lower_reg;
    logic [2:0]          buf_n;
    logic                buf_full;
    logic [63:0]         absorb_word;

    assign buf_n    = buf_reg.valid_bytes[3] ? 3'd7 : buf_reg.valid_bytes[2:0];
    assign buf_full = (buf_reg.cmd == ascon_pkg::CMD_AD_FULL) ||
                      (buf_reg.cmd == ascon_pkg::CMD_PT_FULL);
    assign absorb_word = buf_full ? buf_reg.word_upper
                                  : ((buf_reg.word_upper & byte_mask(buf_n)) | pad_bit(buf_n));

    assign st.out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        if (dp_ctl.load_init)
        begin
            stage0[0] = ascon_pkg::LANE0_IV;
            stage0[1] = key_upper_reg;
            stage0[2] = key_lower_reg;
            stage0[3] = item.word_upper;
            stage0[4] = item.word_lower;
        end
        else
        begin
            stage0 = lanes_reg;
        end
        stage1 = dp_ctl.do_round ? ascon_round(stage0, ascon_pkg::ROUND_CONST[dp_ctl.rc_idx])
                                 : stage0;
        lanes_next    = stage1;
        lanes_next[0] = stage1[0] ^ (dp_ctl.absorb ? absorb_word : 64'd0)
                                  ^ (dp_ctl.pad_only ? pad_bit(3'd0) : 64'd0);
        lanes_next[1] = stage1[1] ^ (dp_ctl.key12 ? key_upper_reg : 64'd0);
        lanes_next[2] = stage1[2] ^ (dp_ctl.key12 ? key_lower_reg : 64'd0);
        lanes_next[3] = stage1[3] ^ (dp_ctl.key34 ? key_upper_reg : 64'd0);
        lanes_next[4] = stage1[4] ^ (dp_ctl.key34 ? key_lower_reg : 64'd0)
                                  ^ {63'd0, dp_ctl.dsep};
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (dp_ctl.load_ct)
        begin
            out_valid_next     = 1'b1;
            out_next.kind      = ascon_pkg::KIND_CT;
            out_next.out_upper = buf_full ? lanes_reg[0] : (lanes_reg[0] & byte_mask(buf_n));
            out_next.out_lower = 64'd0;
            out_next.out_bytes = buf_full ? 4'd8 : {1'b0, buf_n};
            out_next.is_last   = 1'b0;
        end
        else if (dp_ctl.load_tag)
        begin
            out_valid_next     = 1'b1;
            out_next.kind      = ascon_pkg::KIND_TAG;
            out_next.out_upper = lanes_reg[3];
            out_next.out_lower = lanes_reg[4];
            out_next.out_bytes = 4'd8;
            out_next.is_last   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_reg     <= '0;
            out_valid_reg <= 1'b0;
            key_upper_reg <= 64'd0;
            key_lower_reg <= 64'd0;
        end
        else
        begin
            lanes_reg     <= lanes_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == ascon_pkg::CFG_KEY_UPPER)
            begin
                key_upper_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == ascon_pkg::CFG_KEY_LOWER)
            begin
                key_lower_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (dp_ctl.buf_load)
        begin
            buf_reg <= item;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ----- design/ascon_ctrl.sv -----
// Controller: message phase tracking, round counter and the sequencer that
// drives the datapath one step per cycle. Depends on ascon_pkg.
`default_nettype none

module ascon_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    input  wire logic [2:0]             item_cmd,
    output logic                        item_stall,
    output ascon_pkg::dp_ctl_t          dp_ctl,
    input  wire ascon_pkg::dp_status_t  st
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_INIT_RND = 11'b000_0000_0010,
        S_AD_XOR   = 11'b000_0000_0100,
        S_AD_RND   = 11'b000_0000_1000,
        S_CLOSE_RND = 11'b000_0001_0000,
        S_PT_XOR   = 11'b000_0010_0000,
        S_CT_EMIT  = 11'b000_0100_0000,
        S_PT_RND   = 11'b000_1000_0000,
        S_FIN_RND  = 11'b001_0000_0000,
        S_TAG_EMIT = 11'b010_0000_0000,
        S_SPARE    = 11'b100_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_AD   = 2'd1,
        PH_PT   = 2'd2
    } phase_t;

    state_t                     state_reg, state_next;
    phase_t                     phase_reg, phase_next;
    logic                       ad_reg, ad_next;
    logic                       fin_reg, fin_next;
    logic [ascon_pkg::RND_W-1:0] rnd_reg, rnd_next;
    logic                       rnd_last;

    assign rnd_last   = (rnd_reg == ascon_pkg::RND_LAST);
    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        ad_next       = ad_reg;
        fin_next      = fin_reg;
        rnd_next      = rnd_reg;
        dp_ctl        = '0;
        dp_ctl.rc_idx = rnd_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    dp_ctl.buf_load = 1'b1;
                    fin_next = (item_cmd == ascon_pkg::CMD_AD_FINAL) ||
                               (item_cmd == ascon_pkg::CMD_PT_FINAL);
                    case (item_cmd)
                        ascon_pkg::CMD_INIT:
                        begin
                            dp_ctl.load_init = 1'b1;
                            rnd_next   = ascon_pkg::RND_START_A;
                            phase_next = PH_AD;
                            ad_next    = 1'b0;
                            state_next = S_INIT_RND;
                        end
                        ascon_pkg::CMD_AD_FULL, ascon_pkg::CMD_AD_FINAL:
                        begin
                            if (phase_reg == PH_AD)
                            begin
                                state_next = S_AD_XOR;
                            end
                        end
                        ascon_pkg::CMD_PT_FULL, ascon_pkg::CMD_PT_FINAL:
                        begin
                            if (phase_reg == PH_AD && ad_reg)
                            begin
                                dp_ctl.pad_only = 1'b1;
                                rnd_next   = ascon_pkg::RND_START_B;
                                state_next = S_CLOSE_RND;
                            end
                            else if (phase_reg == PH_AD)
                            begin
                                dp_ctl.dsep = 1'b1;
                                phase_next  = PH_PT;
                                state_next  = S_PT_XOR;
                            end
                            else if (phase_reg == PH_PT)
                            begin
                                state_next = S_PT_XOR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INIT_RND:
            begin
                dp_ctl.do_round = 1'b1;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_last)
                begin
                    dp_ctl.key34 = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_AD_XOR:
            begin
                dp_ctl.absorb = 1'b1;
                rnd_next   = ascon_pkg::RND_START_B;
                state_next = S_AD_RND;
            end
            S_AD_RND:
            begin
                dp_ctl.do_round = 1'b1;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_last)
                begin
                    state_next = S_IDLE;
                    if (fin_reg)
                    begin
                        dp_ctl.dsep = 1'b1;
                        phase_next  = PH_PT;
                        ad_next     = 1'b0;
                    end
                    else
                    begin
                        ad_next = 1'b1;
                    end
                end
            end
            S_CLOSE_RND:
            begin
                dp_ctl.do_round = 1'b1;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_last)
                begin
                    dp_ctl.dsep = 1'b1;
                    phase_next  = PH_PT;
                    ad_next     = 1'b0;
                    state_next  = S_PT_XOR;
                end
            end
            S_PT_XOR:
            begin
                dp_ctl.absorb = 1'b1;
                state_next = S_CT_EMIT;
            end
            S_CT_EMIT:
            begin
                if (st.out_free)
                begin
                    dp_ctl.load_ct = 1'b1;
                    if (fin_reg)
                    begin
                        dp_ctl.key12 = 1'b1;
                        rnd_next   = ascon_pkg::RND_START_A;
                        state_next = S_FIN_RND;
                    end
                    else
                    begin
                        rnd_next   = ascon_pkg::RND_START_B;
                        state_next = S_PT_RND;
                    end
                end
            end
            S_PT_RND:
            begin
                dp_ctl.do_round = 1'b1;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FIN_RND:
            begin
                dp_ctl.do_round = 1'b1;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_last)
                begin
                    dp_ctl.key34 = 1'b1;
                    state_next   = S_TAG_EMIT;
                end
            end
            S_TAG_EMIT:
            begin
                if (st.out_free)
                begin
                    dp_ctl.load_tag = 1'b1;
                    phase_next = PH_IDLE;
                    ad_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
            ad_reg    <= 1'b0;
            fin_reg   <= 1'b0;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ad_reg    <= ad_next;
            fin_reg   <= fin_next;
            rnd_reg   <= rnd_next;
        end
    end

    a_ad_open_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ad_reg |-> phase_reg == PH_AD)
        else $error("Open associated data outside the associated data phase.");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_ctl.load_ct || dp_ctl.load_tag) |-> st.out_free)
        else $error("Result register loaded while a transfer is still pending.");

    a_tag_ends_message: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAG_EMIT && st.out_free) |=>
        (phase_reg == PH_IDLE && state_reg == S_IDLE))
        else $error("Message did not close after the tag was loaded.");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT_RND || state_reg == S_AD_RND || state_reg == S_CLOSE_RND ||
         state_reg == S_PT_RND || state_reg == S_FIN_RND) |-> rnd_reg <= ascon_pkg::RND_LAST)
        else $error("Round counter ran past the last round constant.");

    a_pt_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PT_XOR) |-> phase_reg == PH_PT)
        else $error("Plaintext absorbed before domain separation.");

endmodule

`default_nettype wire

// ----- design/ascon128_aead_encrypt.sv -----
// Ascon-128 encryption top level: one round unit used once per cycle.
// Init runs the full permutation, AD and PT full blocks the short one, PT final the
// full one and the tag. A first PT block closes open AD; outputs wait on the result
// register. One item is worked at a time; the result register lets a new item enter
// while a result waits. Async reset rst_n clears state, key, phase and result valid.
`default_nettype none

module ascon128_aead_encrypt (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire ascon_pkg::in_item_t   item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output ascon_pkg::out_item_t       result,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [63:0]           cfg_data
);

    ascon_pkg::dp_ctl_t    dp_ctl;
    ascon_pkg::dp_status_t st;

    ascon_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_cmd   (item.cmd),
        .item_stall (item_stall),
        .dp_ctl     (dp_ctl),
        .st         (st)
    );

    ascon_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_ctl       (dp_ctl),
        .st           (st),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the Ascon-128 encryption block: a bit-accurate sponge
// predictor, a queued transfer driver, and a monitor that checks every result.
// Depends on ascon_pkg and ascon128_aead_encrypt only.
module testbench;

    localparam logic [63:0] IV_WORD     = 64'h8040_0c06_0000_0000;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [2:0]  CMD_RSVD5   = 3'd5;
    localparam logic [2:0]  CMD_RSVD6   = 3'd6;
    localparam logic [2:0]  CMD_RSVD7   = 3'd7;
    localparam int          IDLE_PCT    = 31;
    localparam int          SETTLE      = 40;
    localparam int          STUCK_LIMIT = 1000;

    typedef enum logic [1:0] {MSG_IDLE, MSG_AD, MSG_PT} msg_stage_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    ascon_pkg::in_item_t  item_in = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    ascon_pkg::out_item_t result;
    logic                 cfg_we = 1'b0;
    logic                 cfg_index = ascon_pkg::CFG_KEY_UPPER;
    logic [63:0]          cfg_data = '0;

    logic        item_xfer = 1'b0;
    logic        steady = 1'b0;

    ascon_pkg::in_item_t  pending_blocks[$];
    ascon_pkg::out_item_t cipher_expected[$];

    logic [63:0] sponge [5];
    logic [63:0] key_hi = '0;
    logic [63:0] key_lo = '0;
    msg_stage_t  msg_stage = MSG_IDLE;
    logic        ad_open = 1'b0;

    int errors = 0;
    int items_taken = 0;
    int ct_checked = 0;
    int tags_checked = 0;
    int stuck = 0;

    ascon128_aead_encrypt u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
        return (v >> n) | (v << (64 - n));
    endfunction

    function automatic logic [63:0] keep_mask(input int n);
        return (n == 0) ? 64'd0 : (ALL_ONES << (64 - 8 * n));
    endfunction

    function automatic logic [63:0] pad_bit(input int n);
        return 64'h80 << (56 - 8 * n);
    endfunction

    task automatic sponge_round(input logic [7:0] rc);
        logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
        begin
            x0 = sponge[0];
            x1 = sponge[1];
            x2 = sponge[2] ^ 64'(rc);
            x3 = sponge[3];
            x4 = sponge[4];
            x0 ^= x4;
            x4 ^= x3;
            x2 ^= x1;
            t0 = ~x0 & x1;
            t1 = ~x1 & x2;
            t2 = ~x2 & x3;
            t3 = ~x3 & x4;
            t4 = ~x4 & x0;
            x0 ^= t1;
            x1 ^= t2;
            x2 ^= t3;
            x3 ^= t4;
            x4 ^= t0;
            x1 ^= x0;
            x0 ^= x4;
            x3 ^= x2;
            x2 = ~x2;
            sponge[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
            sponge[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
            sponge[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
            sponge[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
            sponge[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
        end
    endtask

    task automatic permute(input int rounds);
        int r;
        begin
            for (r = 12 - rounds; r < 12; r++)
                sponge_round({4'(15 - r), 4'(r)});
        end
    endtask

    task automatic encrypt_step(input ascon_pkg::in_item_t it);
        int n;
        logic [63:0] blk;
        begin
            n = (it.valid_bytes > 4'd7) ? 7 : int'(it.valid_bytes);
            blk = (it.word_upper & keep_mask(n)) | pad_bit(n);
            case (it.cmd)
                ascon_pkg::CMD_INIT:
                begin
                    sponge[0] = IV_WORD;
                    sponge[1] = key_hi;
                    sponge[2] = key_lo;
                    sponge[3] = it.word_upper;
                    sponge[4] = it.word_lower;
                    permute(ascon_pkg::ROUNDS_A);
                    sponge[3] ^= key_hi;
                    sponge[4] ^= key_lo;
                    msg_stage = MSG_AD;
                    ad_open = 1'b0;
                end
                ascon_pkg::CMD_AD_FULL:
                    if (msg_stage == MSG_AD)
                    begin
                        sponge[0] ^= it.word_upper;
                        permute(ascon_pkg::ROUNDS_B);
                        ad_open = 1'b1;
                    end
                ascon_pkg::CMD_AD_FINAL:
                    if (msg_stage == MSG_AD)
                    begin
                        sponge[0] ^= blk;
                        permute(ascon_pkg::ROUNDS_B);
                        ad_open = 1'b0;
                        sponge[4] ^= 64'd1;
                        msg_stage = MSG_PT;
                    end
                ascon_pkg::CMD_PT_FULL, ascon_pkg::CMD_PT_FINAL:
                    if (msg_stage != MSG_IDLE)
                    begin
                        if (msg_stage == MSG_AD)
                        begin
                            if (ad_open)
                            begin
                                sponge[0] ^= pad_bit(0);
                                permute(ascon_pkg::ROUNDS_B);
                            end
                            ad_open = 1'b0;
                            sponge[4] ^= 64'd1;
                            msg_stage = MSG_PT;
                        end
                        if (it.cmd == ascon_pkg::CMD_PT_FULL)
                        begin
                            sponge[0] ^= it.word_upper;
                            cipher_expected.push_back('{kind: ascon_pkg::KIND_CT,
                                out_upper: sponge[0], out_lower: 64'd0, out_bytes: 4'd8,
                                is_last: 1'b0});
                            permute(ascon_pkg::ROUNDS_B);
                        end
                        else
                        begin
                            sponge[0] ^= blk;
                            cipher_expected.push_back('{kind: ascon_pkg::KIND_CT,
                                out_upper: sponge[0] & keep_mask(n), out_lower: 64'd0,
                                out_bytes: 4'(n), is_last: 1'b0});
                            sponge[1] ^= key_hi;
                            sponge[2] ^= key_lo;
                            permute(ascon_pkg::ROUNDS_A);
                            sponge[3] ^= key_hi;
                            sponge[4] ^= key_lo;
                            cipher_expected.push_back('{kind: ascon_pkg::KIND_TAG,
                                out_upper: sponge[3], out_lower: sponge[4], out_bytes: 4'd8,
                                is_last: 1'b1});
                            msg_stage = MSG_IDLE;
                            ad_open = 1'b0;
                        end
                    end
                default:
                    ;
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        begin
            if (want !== got)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        end
    endtask

    // Driver: a new transfer is offered only once the previous one has been taken.
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_xfer))
        begin
            if (pending_blocks.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                item_in <= pending_blocks.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
        result_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // Monitor: predicts on accepted inputs, checks accepted results, guards progress.
    always @(posedge clk)
    begin
        ascon_pkg::out_item_t want;
        logic progress;
        progress = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                progress = 1'b1;
                if (cfg_index == ascon_pkg::CFG_KEY_UPPER)
                    key_hi = cfg_data;
                else
                    key_lo = cfg_data;
            end
            if (item_valid && !item_stall)
            begin
                progress = 1'b1;
                items_taken++;
                encrypt_step(item_in);
            end
            if (result_valid && !result_stall)
            begin
                progress = 1'b1;
                if (cipher_expected.size() == 0)
                begin
                    errors++;
                    if (errors <= 40)
                        $display("%0t: unexpected result, expected none, got %h",
                                 $time, result);
                end
                else
                begin
                    want = cipher_expected.pop_front();
                    check_field("kind", 64'(want.kind), 64'(result.kind));
                    check_field("out_upper", want.out_upper, result.out_upper);
                    check_field("out_lower", want.out_lower, result.out_lower);
                    check_field("out_bytes", 64'(want.out_bytes), 64'(result.out_bytes));
                    check_field("is_last", 64'(want.is_last), 64'(result.is_last));
                    if (want.kind == ascon_pkg::KIND_TAG)
                        tags_checked++;
                    else
                        ct_checked++;
                end
            end
            stuck = progress ? 0 : stuck + 1;
        end
        item_xfer <= rst_n && item_valid && !item_stall;
        if (stuck >= STUCK_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, stuck, cipher_expected.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [3:0] final_bytes();
        return ($urandom_range(9) == 0) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(7));
    endfunction

    function automatic ascon_pkg::in_item_t make_item(input logic [2:0] cmd,
                                                      input logic [63:0] upper,
                                                      input logic [63:0] lower,
                                                      input logic [3:0] vb);
        return '{cmd: cmd, word_upper: upper, word_lower: lower, valid_bytes: vb};
    endfunction

    task automatic set_key(input logic [63:0] upper, input logic [63:0] lower);
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= ascon_pkg::CFG_KEY_UPPER;
            cfg_data <= upper;
            @(negedge clk);
            cfg_index <= ascon_pkg::CFG_KEY_LOWER;
            cfg_data <= lower;
            @(negedge clk);
            cfg_we <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        begin
            @(negedge clk);
            while (pending_blocks.size() != 0 || item_valid || cipher_expected.size() != 0)
                @(negedge clk);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    // Mostly complete messages with random AD and PT lengths; some are cut short
    // by a fresh init, and a few stray transfers land in any stage.
    task automatic queue_random_traffic(input int target);
        int added, start_size, n_ad, n_pt, k;
        begin
            added = 0;
            while (added < target)
            begin
                start_size = pending_blocks.size();
                if ($urandom_range(99) < 8)
                    pending_blocks.push_back(make_item(3'($urandom_range(7)), rand_word(),
                                                       rand_word(), 4'($urandom_range(15))));
                else
                begin
                    pending_blocks.push_back(make_item(ascon_pkg::CMD_INIT, rand_word(),
                                                       rand_word(), 4'($urandom_range(15))));
                    n_ad = $urandom_range(3);
                    n_pt = $urandom_range(4);
                    for (k = 0; k < n_ad; k++)
                        pending_blocks.push_back(make_item(ascon_pkg::CMD_AD_FULL, rand_word(),
                                                           rand_word(), 4'($urandom_range(15))));
                    if ($urandom_range(2) != 0)
                        pending_blocks.push_back(make_item(ascon_pkg::CMD_AD_FINAL, rand_word(),
                                                           rand_word(), final_bytes()));
                    for (k = 0; k < n_pt; k++)
                        pending_blocks.push_back(make_item(ascon_pkg::CMD_PT_FULL, rand_word(),
                                                           rand_word(), 4'($urandom_range(15))));
                    if ($urandom_range(19) != 0)
                        pending_blocks.push_back(make_item(ascon_pkg::CMD_PT_FINAL, rand_word(),
                                                           rand_word(), final_bytes()));
                end
                added += pending_blocks.size() - start_size;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < 5; i++)
            sponge[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_key(64'd0, 64'd0);
        pending_blocks.push_back(make_item(ascon_pkg::CMD_PT_FINAL, ALL_ONES, ALL_ONES, 4'd4));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_AD_FULL, ALL_ONES, ALL_ONES, 4'd8));
        pending_blocks.push_back(make_item(CMD_RSVD5, ALL_ONES, ALL_ONES, 4'd15));
        pending_blocks.push_back(make_item(CMD_RSVD7, 64'd0, 64'd0, 4'd0));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_INIT, 64'd0, 64'd0, 4'd0));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_PT_FINAL, ALL_ONES, 64'd0, 4'd0));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_INIT, ALL_ONES, ALL_ONES, 4'd15));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_AD_FULL, ALL_ONES, 64'd0, 4'd8));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_AD_FINAL, ALL_ONES, ALL_ONES, 4'd7));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_PT_FULL, ALL_ONES, 64'd0, 4'd8));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_PT_FINAL, ALL_ONES, ALL_ONES, 4'd15));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_INIT, rand_word(), rand_word(), 4'd8));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_AD_FULL, rand_word(), rand_word(),
                                           4'd0));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_PT_FULL, rand_word(), rand_word(),
                                           4'd8));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_PT_FINAL, rand_word(), rand_word(),
                                           4'd8));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_INIT, rand_word(), rand_word(), 4'd0));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_AD_FINAL, rand_word(), rand_word(),
                                           4'd0));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_AD_FULL, rand_word(), rand_word(),
                                           4'd8));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_PT_FINAL, rand_word(), rand_word(),
                                           4'd3));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_INIT, rand_word(), rand_word(), 4'd0));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_INIT, rand_word(), rand_word(), 4'd0));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_AD_FINAL, rand_word(), rand_word(),
                                           4'd5));
        pending_blocks.push_back(make_item(CMD_RSVD6, rand_word(), rand_word(), 4'd9));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_PT_FINAL, rand_word(), rand_word(),
                                           4'd7));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_INIT, rand_word(), rand_word(), 4'd0));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_AD_FULL, rand_word(), rand_word(),
                                           4'd0));
        pending_blocks.push_back(make_item(ascon_pkg::CMD_PT_FINAL, rand_word(), rand_word(),
                                           4'd0));
        wait_drained();

        set_key(ALL_ONES, ALL_ONES);
        queue_random_traffic(300);
        wait_drained();

        set_key(rand_word(), rand_word());
        steady = 1'b1;
        queue_random_traffic(300);
        wait_drained();
        steady = 1'b0;

        set_key(64'd0, ALL_ONES);
        queue_random_traffic(300);
        wait_drained();

        set_key(rand_word(), rand_word());
        queue_random_traffic(300);
        wait_drained();

        $display("Ran %0d input transfers under five keys, zero and all-ones among them,",
                 items_taken);
        $display("and checked %0d ciphertext words and %0d tags.", ct_checked, tags_checked);
        if (errors == 0 && cipher_expected.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- sim.f -----
design/ascon_pkg.sv
design/ascon_datapath.sv
design/ascon_ctrl.sv
design/ascon128_aead_encrypt.sv
bench/testbench.sv
